// ===== design/elfr_pkg.sv =====
// ----------------------------------------------------------------------------
// elfr_pkg
// Types and constants shared by the escaped length frame receiver.
// ----------------------------------------------------------------------------
package elfr_pkg;

    localparam int CNT_W  = 13;
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'hFD;
    localparam logic [BYTE_W-1:0] ESC_BYTE       = 8'hFC;
    localparam logic [BYTE_W-1:0] ESC_MASK       = 8'h80;
    localparam logic [LEN_W:0]    FRAME_OVERHEAD = 17'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_MSB  = 2'd1,
        PH_LSB  = 2'd2,
        PH_HAVE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IN_FRAME = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_SYNC_ERR = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_RESTART  = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        status_t           status;
        logic              last;
        logic [CNT_W-1:0]  frame_position;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

endpackage

// ===== design/elfr_core.sv =====
// ----------------------------------------------------------------------------
// elfr_core
// Frame delimiting state and per-byte decode; one byte per fire.
// ----------------------------------------------------------------------------
module elfr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            rx_byte,
    input  logic [12:0]           limit,
    output elfr_pkg::result_t     result
);
    import elfr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   raw_reg, raw_next;
    logic [CNT_W-1:0]   nonesc_reg, nonesc_next;
    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    phase_t             phase_s;
    logic [CNT_W-1:0]   raw_s;
    logic [CNT_W-1:0]   nonesc_s;
    logic               pend_s;
    logic [LEN_W-1:0]   len_s;
    logic [BYTE_W-1:0]  val;
    logic               is_sync;
    logic               complete;
    logic               trunc;

    assign is_sync = (rx_byte == SYNC_BYTE);
    assign val     = rx_byte | (pend_reg ? ESC_MASK : '0);

    // step of the frame state for this byte
    always_comb
    begin
        phase_s  = phase_reg;
        raw_s    = raw_reg;
        nonesc_s = nonesc_reg;
        pend_s   = pend_reg;
        len_s    = len_reg;
        complete = 1'b0;
        if (is_sync)
        begin
            phase_s  = PH_MSB;
            raw_s    = CNT_W'(1);
            nonesc_s = CNT_W'(1);
            pend_s   = 1'b0;
            len_s    = '0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            raw_s = raw_reg + CNT_W'(1);
            if (rx_byte == ESC_BYTE)
            begin
                pend_s = 1'b1;
            end
            else
            begin
                pend_s   = 1'b0;
                nonesc_s = nonesc_reg + CNT_W'(1);
                unique case (phase_reg)
                    PH_MSB:
                    begin
                        len_s   = {val, 8'h00};
                        phase_s = PH_LSB;
                    end
                    PH_LSB:
                    begin
                        len_s   = {len_reg[15:8], val};
                        phase_s = PH_HAVE;
                    end
                    PH_HAVE:
                    begin
                        complete = ({4'd0, nonesc_s} >= ({1'b0, len_reg} + FRAME_OVERHEAD));
                    end
                    default:
                    begin
                        phase_s = phase_reg;
                    end
                endcase
            end
        end
        trunc = (phase_s != PH_IDLE) && !complete && (raw_s >= limit);
    end

    // next state
    always_comb
    begin
        if (complete || trunc)
        begin
            phase_next  = PH_IDLE;
            raw_next    = '0;
            nonesc_next = '0;
            pend_next   = 1'b0;
            len_next    = '0;
        end
        else
        begin
            phase_next  = phase_s;
            raw_next    = raw_s;
            nonesc_next = nonesc_s;
            pend_next   = pend_s;
            len_next    = len_s;
        end
    end

    // result
    always_comb
    begin
        result.out_byte = rx_byte;
        result.last     = complete || trunc;
        priority if (trunc)
            result.status = ST_TRUNC;
        else if (complete)
            result.status = ST_COMPLETE;
        else if (is_sync)
            result.status = (phase_reg != PH_IDLE) ? ST_RESTART : ST_IN_FRAME;
        else if (phase_reg == PH_IDLE)
            result.status = ST_SYNC_ERR;
        else
            result.status = ST_IN_FRAME;
        result.frame_position = (phase_s != PH_IDLE) ? raw_s : '0;
        result.payload_length = (phase_s == PH_HAVE) ? len_s : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            raw_reg    <= '0;
            nonesc_reg <= '0;
            pend_reg   <= 1'b0;
            len_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            raw_reg    <= raw_next;
            nonesc_reg <= nonesc_next;
            pend_reg   <= pend_next;
            len_reg    <= len_next;
        end
    end

endmodule

// ===== design/escaped_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// escaped_length_frame_receiver
// Delimits sync-started, escape-stuffed, length-prefixed frames in a byte
// stream.
// ----------------------------------------------------------------------------
// Usage:
//   Raw serial bytes enter on s_tdata[7:0]. Each byte yields exactly one
//   transfer on the master side: the byte itself, its position in the frame
//   and the decoded length on m_tdata, a status code on m_tuser, and m_tlast
//   on the byte that completes or truncates a frame.
//   cfg_we/cfg_wdata write max_frame_bytes (clamped to BUFFER_BYTES and to 8191,
//   zero acts as one); write it only while no byte is in flight.
//   m_tvalid rises once a byte has passed the input register, then the result
//   register. Throughput: one byte per cycle while m_tready is high, set by the
//   state update in the decode core.
//   Reset: the receiver is idle waiting for sync, both pipeline stages are
//   empty and the limit returns to 4096 (clamped to BUFFER_BYTES).
//   Stall: when m_tready is low the result holds, the input register fills
//   and s_tready drops once it is full; no byte is lost or repeated.
// ----------------------------------------------------------------------------
module escaped_length_frame_receiver #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] out_byte, [20:8] frame_position,
                                    // [36:21] payload_length, [39:37] zero
    output logic [2:0]  m_tuser,    // [2:0] status
    output logic        m_tlast
);
    import elfr_pkg::*;

    localparam int CAP       = (BUFFER_BYTES > 8191) ? 8191 : BUFFER_BYTES;
    localparam int LIM_RESET = (CAP < 4096) ? CAP : 4096;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic              advance;
    logic              fire;
    result_t           result;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        if (cfg_wdata > CNT_W'(CAP))
            limit_next = CNT_W'(CAP);
        else if (cfg_wdata == '0)
            limit_next = CNT_W'(1);
        else
            limit_next = cfg_wdata;
    end

    elfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .limit   (limit_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= CNT_W'(LIM_RESET);
        end
        else
        begin
            if (cfg_we)
                limit_reg <= limit_next;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (fire)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.payload_length, out_reg.frame_position,
                       out_reg.out_byte};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser == ST_COMPLETE || m_tuser == ST_TRUNC))
        else $error("last on a byte that does not end a frame");

    a_sync_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_SYNC_ERR |-> m_tdata[36:8] == '0 && !m_tlast)
        else $error("sync error carries frame data");

    a_pos_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_SYNC_ERR |-> m_tdata[20:8] != '0 &&
        m_tdata[20:8] <= CNT_W'(CAP))
        else $error("frame position out of range");

    a_limit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg != '0 && limit_reg <= CNT_W'(CAP))
        else $error("frame limit out of range");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("buffered byte lost during stall");
`endif

endmodule
